### rtl/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the hasher RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/sha_pkg.sv
//------------------------------------------------------------------------------
// SHA-256 hasher package
// Types, constants and round functions shared by the hasher modules.
//------------------------------------------------------------------------------
package sha_pkg;

   localparam logic [1:0] MODE_ABSORB = 2'd0;
   localparam logic [1:0] MODE_FINISH = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [5:0] LEN_POS   = 6'd56;
   localparam logic [5:0] LAST_POS  = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD = 3'd7;
   localparam logic [2:0] MAX_BYTES = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] data_word;
      logic [2:0]  byte_count;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } rsp_payload_type;

   // Commands from the sequencer to the compression core.
   typedef struct packed {
      logic        init;
      logic        load;
      logic [31:0] word;
      logic        start;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_status_type;

   typedef logic [7:0][31:0] chain_type;

   localparam chain_type IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
      endcase
      round_k = k;
   endfunction

endpackage

### rtl/sha_core.sv
//------------------------------------------------------------------------------
// SHA-256 compression core
// Message schedule window, working variables and one round unit reused 64 times.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module sha_core (
   input  logic                     clock,
   input  logic                     reset,
   input  sha_pkg::core_ctl_type    ctl,
   output sha_pkg::core_status_type status,
   output sha_pkg::chain_type       chain
);

   typedef enum logic [2:0] {
      CS_IDLE = 3'b001,
      CS_RUN  = 3'b010,
      CS_ADD  = 3'b100
   } core_state_type;

   core_state_type   state_ff, state_in;
   logic [5:0]       rnd_ff, rnd_in;
   logic [31:0]      win_ff [16];
   logic [31:0]      var_ff [8];
   sha_pkg::chain_type cv_ff, cv_in;
   logic [31:0]      w_new, t1, t2, s0, s1;

   // Schedule word for round t+16, computed from the window that holds t..t+15, and the round terms t1 and t2.
   always_comb begin
      s0 = sha_pkg::rotr(win_ff[1], 7) ^ sha_pkg::rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
      s1 = sha_pkg::rotr(win_ff[14], 17) ^ sha_pkg::rotr(win_ff[14], 19)
           ^ (win_ff[14] >> 10);
      w_new = s1 + win_ff[9] + s0 + win_ff[0];
      t1 = var_ff[7]
           + (sha_pkg::rotr(var_ff[4], 6) ^ sha_pkg::rotr(var_ff[4], 11)
              ^ sha_pkg::rotr(var_ff[4], 25))
           + (var_ff[6] ^ (var_ff[4] & (var_ff[5] ^ var_ff[6])))
           + sha_pkg::round_k(rnd_ff) + win_ff[0];
      t2 = (sha_pkg::rotr(var_ff[0], 2) ^ sha_pkg::rotr(var_ff[0], 13)
            ^ sha_pkg::rotr(var_ff[0], 22))
           + ((var_ff[0] & var_ff[1]) | (var_ff[2] & (var_ff[0] | var_ff[1])));
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      cv_in    = cv_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (ctl.start) begin
               state_in = CS_RUN;
               rnd_in   = '0;
            end
         end
         CS_RUN: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == sha_pkg::LAST_ROUND) begin
               state_in = CS_ADD;
            end
         end
         CS_ADD: begin
            state_in = CS_IDLE;
            for (int i = 0; i < 8; i++) begin
               cv_in[i] = cv_ff[i] + var_ff[i];
            end
         end
         default: state_in = CS_IDLE;
      endcase
      if (ctl.init) begin
         cv_in = sha_pkg::IV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         rnd_ff   <= '0;
         cv_ff    <= sha_pkg::IV;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         cv_ff    <= cv_in;
      end
   end

   // Window and working variables carry data only.
   always_ff @(posedge clock) begin
      if (ctl.load || state_ff == CS_RUN) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[15] <= ctl.load ? ctl.word : w_new;
      end
      if (state_ff == CS_IDLE && ctl.start) begin
         for (int i = 0; i < 8; i++) begin
            var_ff[i] <= cv_ff[i];
         end
      end else if (state_ff == CS_RUN) begin
         for (int i = 7; i > 0; i--) begin
            var_ff[i] <= var_ff[i - 1];
         end
         var_ff[4] <= var_ff[3] + t1;
         var_ff[0] <= t1 + t2;
      end
   end

   assign status.busy = (state_ff != CS_IDLE);
   assign status.done = (state_ff == CS_ADD);
   assign chain       = cv_ff;

   `ASSERT_NEXT(a_start_runs, clock, reset, state_ff == CS_IDLE && ctl.start, state_ff == CS_RUN)
   `ASSERT_NEXT(a_last_round_adds, clock, reset,
                state_ff == CS_RUN && rnd_ff == sha_pkg::LAST_ROUND, state_ff == CS_ADD)
   `ASSERT_SAME(a_no_load_when_busy, clock, reset, state_ff != CS_IDLE, !ctl.load && !ctl.start)

endmodule

### rtl/sha256_hasher_unit.sv
//------------------------------------------------------------------------------
// SHA-256 hasher unit
// Byte sequencer, padding, length counter and digest output around the core.
//------------------------------------------------------------------------------
// The unit takes one transaction at a time and stalls its request channel
// until that transaction is done. Absorb moves one message byte per cycle
// into the block, except while a completed block is compressed, and then
// returns to idle (a count of zero moves no byte; counts above four act as
// four). When a byte completes a 64-byte block, the compression core runs
// its single round unit through the 64 rounds and then folds the result
// into the chaining value. Finish feeds the 0x80 marker, zero fill and the
// 64-bit big-endian bit length through the same byte path, one byte per
// cycle except while a block is compressed, compresses one or two blocks,
// then presents the eight digest words on the response channel, word 0
// first, one per cycle unless stalled; the eighth transaction carries
// last. Afterwards the unit is back at the initial hash value with a zero
// length, exactly as after clear. Clear is done without leaving idle.
// Mode 3 is accepted and ignored.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_hasher_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sha_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sha_pkg::rsp_payload_type rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ABSORB = 5'b00010,
      ST_PAD    = 5'b00100,
      ST_COMP   = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type   state_ff, state_in, ret_ff, ret_in;
   logic [60:0] msg_ff, msg_in;      // total message length in bytes
   logic [5:0]  pos_ff, pos_in;      // byte position within the current block
   logic [2:0]  cnt_ff, cnt_in;      // bytes left in the absorb transaction
   logic [2:0]  idx_ff, idx_in;      // digest word being presented
   logic        lenblk_ff, lenblk_in;
   logic        first_ff, first_in;
   logic [31:0] data_ff, data_in;
   logic [63:0] len_ff, len_in;
   logic [23:0] word_ff, word_in;

   logic                      req_take, rsp_take, feed, len_byte;
   logic [7:0]                fbyte;
   logic [2:0]                sat_count;
   sha_pkg::core_ctl_type     ctl;
   sha_pkg::core_status_type  status;
   sha_pkg::chain_type        chain;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign sat_count = (req_data.byte_count > sha_pkg::MAX_BYTES) ? sha_pkg::MAX_BYTES
                                                                 : req_data.byte_count;

   // Byte source shared by absorb and padding. In padding, the length bytes
   // go only into the block that ends the message.
   always_comb begin
      feed     = 1'b0;
      fbyte    = '0;
      len_byte = 1'b0;
      if (state_ff == ST_ABSORB && cnt_ff != 3'd0) begin
         feed  = 1'b1;
         fbyte = data_ff[31:24];
      end else if (state_ff == ST_PAD) begin
         feed = 1'b1;
         if (first_ff) begin
            fbyte = sha_pkg::PAD_BYTE;
         end else if (lenblk_ff && pos_ff >= sha_pkg::LEN_POS) begin
            len_byte = 1'b1;
            fbyte    = len_ff[63:56];
         end
      end
   end

   always_comb begin
      ctl.load  = feed && (pos_ff[1:0] == 2'b11);
      ctl.word  = {word_ff, fbyte};
      ctl.start = feed && (pos_ff == sha_pkg::LAST_POS);
      ctl.init  = (req_take && req_data.mode == sha_pkg::MODE_CLEAR)
                  || (rsp_take && idx_ff == sha_pkg::LAST_WORD);
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      msg_in    = msg_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      lenblk_in = lenblk_ff;
      first_in  = first_ff;
      data_in   = data_ff;
      len_in    = len_ff;
      word_in   = feed ? {word_ff[15:0], fbyte} : word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_data.mode)
                  sha_pkg::MODE_ABSORB: begin
                     data_in  = req_data.data_word;
                     cnt_in   = sat_count;
                     state_in = ST_ABSORB;
                  end
                  sha_pkg::MODE_FINISH: begin
                     len_in    = {msg_ff, 3'b000};
                     lenblk_in = (pos_ff < sha_pkg::LEN_POS);
                     first_in  = 1'b1;
                     state_in  = ST_PAD;
                  end
                  sha_pkg::MODE_CLEAR: begin
                     msg_in = '0;
                     pos_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_ABSORB: begin
            if (cnt_ff == 3'd0) begin
               state_in = ST_IDLE;
            end else begin
               data_in = {data_ff[23:0], 8'h00};
               cnt_in  = cnt_ff - 3'd1;
               msg_in  = msg_ff + 61'd1;
               pos_in  = pos_ff + 6'd1;
               if (ctl.start) begin
                  state_in = ST_COMP;
                  ret_in   = ST_ABSORB;
               end
            end
         end
         ST_PAD: begin
            first_in = 1'b0;
            pos_in   = pos_ff + 6'd1;
            if (len_byte) begin
               len_in = {len_ff[55:0], 8'h00};
            end
            if (ctl.start) begin
               state_in  = ST_COMP;
               ret_in    = lenblk_ff ? ST_EMIT : ST_PAD;
               lenblk_in = 1'b1;
               idx_in    = '0;
            end
         end
         ST_COMP: begin
            if (status.done) begin
               state_in = ret_ff;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == sha_pkg::LAST_WORD) begin
                  state_in = ST_IDLE;
                  msg_in   = '0;
                  pos_in   = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ret_ff    <= ST_IDLE;
         msg_ff    <= '0;
         pos_ff    <= '0;
         cnt_ff    <= '0;
         idx_ff    <= '0;
         lenblk_ff <= 1'b0;
         first_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         msg_ff    <= msg_in;
         pos_ff    <= pos_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         lenblk_ff <= lenblk_in;
         first_ff  <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      len_ff  <= len_in;
      word_ff <= word_in;
   end

   sha_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .status (status),
      .chain  (chain)
   );

   always_comb begin
      rsp_data.digest_word = chain[idx_ff];
      rsp_data.word_index  = idx_ff;
      rsp_data.last        = (idx_ff == sha_pkg::LAST_WORD);
   end

   `ASSERT_SAME(a_no_rsp_while_core_busy, clock, reset, status.busy, !rsp_valid)
   `ASSERT_SAME(a_start_at_block_end, clock, reset, ctl.start,
                pos_ff == sha_pkg::LAST_POS && ctl.load)
   `ASSERT_NEXT(a_idle_after_last, clock, reset,
                rsp_take && idx_ff == sha_pkg::LAST_WORD, !rsp_valid && pos_ff == 6'd0)

endmodule

### tb/tb.sv
//------------------------------------------------------------------------------
// SHA-256 hasher unit testbench
// Drives absorb, finish, clear and unused-mode transactions with random idle
// gaps and receiver stalls, predicts every digest word with a local SHA-256
// model and checks each response transaction against it in order.
//------------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 800000;
   localparam int TARGET_ITEMS = 450;
   localparam int DRAIN_CYCLES = 300;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [31:0] RK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   sha_pkg::req_payload_type req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   sha_pkg::rsp_payload_type rsp_data;

   sha256_hasher_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Pending request transactions and the digest words still to arrive.
   sha_pkg::req_payload_type pending_req_q[$];
   sha_pkg::rsp_payload_type digest_q[$];

   // Local hash state.
   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   logic [60:0] msg_len;

   int mismatch_count = 0;
   int cycle_count = 0;
   int digests_seen = 0;
   bit running = 1'b0;
   bit req_taken = 1'b0;

   task automatic report(input string msg);
      $display("ERROR: %s", msg);
      mismatch_count++;
   endtask

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_message();
      for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::IV[i];
      msg_len = '0;
   endtask

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + RK[t] + w[t];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   // Updates the local hash state for one accepted transaction and queues
   // the digest words that a finish produces.
   task automatic predict_digest(input sha_pkg::req_payload_type r);
      int n;
      int pos;
      logic [63:0] bits;
      sha_pkg::rsp_payload_type d;
      case (r.mode)
         sha_pkg::MODE_ABSORB: begin
            n = (r.byte_count > sha_pkg::MAX_BYTES) ? 4 : int'(r.byte_count);
            for (int i = 0; i < n; i++) begin
               pos = int'(msg_len[5:0]);
               msg_block[pos] = r.data_word[31-8*i -: 8];
               msg_len++;
               if (pos == 63) compress_block();
            end
         end
         sha_pkg::MODE_CLEAR: restart_message();
         sha_pkg::MODE_FINISH: begin
            pos = int'(msg_len[5:0]);
            bits = {msg_len, 3'b000};
            msg_block[pos] = sha_pkg::PAD_BYTE;
            pos++;
            if (pos > 56) begin
               for (int i = pos; i < 64; i++) msg_block[i] = 8'h00;
               compress_block();
               pos = 0;
            end
            for (int i = pos; i < 56; i++) msg_block[i] = 8'h00;
            for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
               d.digest_word = hash_state[i];
               d.word_index = 3'(i);
               d.last = (i == 7);
               digest_q.push_back(d);
            end
            restart_message();
         end
         default: ;
      endcase
   endtask

   function automatic sha_pkg::req_payload_type make_req(input logic [1:0] m,
                                                         input logic [31:0] d,
                                                         input logic [2:0] c);
      sha_pkg::req_payload_type r;
      r.mode = m;
      r.data_word = d;
      r.byte_count = c;
      return r;
   endfunction

   // Queues one message of roughly the given length followed by a finish,
   // with occasional noise transactions mixed in.
   task automatic queue_message(input int target_len);
      int got;
      int c;
      got = 0;
      while (got < target_len) begin
         c = $urandom_range(1, 4);
         if ($urandom_range(0, 19) == 0) c = $urandom_range(0, 7);
         if (target_len - got < 4 && $urandom_range(0, 3) != 0) c = target_len - got;
         pending_req_q.push_back(make_req(sha_pkg::MODE_ABSORB, $urandom, 3'(c)));
         got += (c > 4) ? 4 : c;
         if ($urandom_range(0, 39) == 0)
            pending_req_q.push_back(make_req(MODE_UNUSED, $urandom, 3'($urandom_range(0, 7))));
         if ($urandom_range(0, 79) == 0) begin
            pending_req_q.push_back(make_req(sha_pkg::MODE_CLEAR, $urandom,
                                             3'($urandom_range(0, 7))));
            got = 0;
         end
      end
      pending_req_q.push_back(make_req(sha_pkg::MODE_FINISH, $urandom,
                                       3'($urandom_range(0, 7))));
   endtask

   // Request driver: a transaction is held until it is taken, then the next
   // one follows after a random gap.
   int req_gap = 0;
   bit req_busy_burst = 1'b0;

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (running && req_valid && !req_stall) predict_digest(req_data);
   end

   always @(negedge clock) begin
      if (running) begin
         if (req_valid && !req_taken) begin
            req_valid <= 1'b1;
         end else if (req_gap > 0 || pending_req_q.size() == 0) begin
            if (req_gap > 0) req_gap--;
            req_valid <= 1'b0;
         end else begin
            req_data <= pending_req_q.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 49) == 0) req_busy_burst = !req_busy_burst;
            if (req_busy_burst || $urandom_range(0, 9) < 6) req_gap = 0;
            else if ($urandom_range(0, 9) == 0) req_gap = $urandom_range(20, 60);
            else req_gap = $urandom_range(1, 4);
         end
      end
   end

   // Response monitor and stall generator. Once, after a few digests, the
   // receiver holds off for a long stretch so the unit backs up its input.
   int rsp_gap = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      if (running && rsp_valid && !rsp_stall) begin
         digests_seen++;
         if (digest_q.size() == 0) begin
            report($sformatf("unexpected digest word %h", rsp_data.digest_word));
         end else begin
            sha_pkg::rsp_payload_type e;
            e = digest_q.pop_front();
            if (rsp_data.digest_word !== e.digest_word)
               report($sformatf("digest word %0d: got %h, want %h", e.word_index,
                                rsp_data.digest_word, e.digest_word));
            if (rsp_data.word_index !== e.word_index)
               report($sformatf("word index: got %0d, want %0d", rsp_data.word_index,
                                e.word_index));
            if (rsp_data.last !== e.last)
               report($sformatf("last flag on word %0d: got %b, want %b", e.word_index,
                                rsp_data.last, e.last));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && digests_seen >= 24) begin
         hold_done = 1'b1;
         hold_left = 600;
         rsp_stall <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 9) < 6) rsp_gap = 0;
         else if ($urandom_range(0, 14) == 0) rsp_gap = $urandom_range(15, 50);
         else rsp_gap = $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         report($sformatf("timeout after %0d cycles", cycle_count));
         $display("TEST FAILED");
         $finish;
      end
   end

   int target;

   initial begin
      restart_message();
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;

      // Directed part: empty message, a short message, the ignored mode,
      // zero and oversized byte counts, all-ones and all-zero data, clear.
      pending_req_q.push_back(make_req(sha_pkg::MODE_FINISH, 32'h0, 3'd0));
      pending_req_q.push_back(make_req(sha_pkg::MODE_ABSORB, 32'h61626300, 3'd3));
      pending_req_q.push_back(make_req(sha_pkg::MODE_FINISH, 32'hffffffff, 3'd7));
      pending_req_q.push_back(make_req(MODE_UNUSED, 32'hffffffff, 3'd7));
      pending_req_q.push_back(make_req(sha_pkg::MODE_ABSORB, 32'hffffffff, 3'd0));
      pending_req_q.push_back(make_req(sha_pkg::MODE_ABSORB, 32'hffffffff, 3'd7));
      pending_req_q.push_back(make_req(sha_pkg::MODE_ABSORB, 32'h00000000, 3'd5));
      pending_req_q.push_back(make_req(sha_pkg::MODE_ABSORB, 32'h12345678, 3'd6));
      pending_req_q.push_back(make_req(sha_pkg::MODE_FINISH, 32'h0, 3'd4));
      pending_req_q.push_back(make_req(sha_pkg::MODE_ABSORB, 32'hdeadbeef, 3'd4));
      pending_req_q.push_back(make_req(sha_pkg::MODE_CLEAR, 32'hffffffff, 3'd7));
      pending_req_q.push_back(make_req(sha_pkg::MODE_ABSORB, 32'hffffffff, 3'd1));
      pending_req_q.push_back(make_req(sha_pkg::MODE_ABSORB, 32'h80000000, 3'd2));
      pending_req_q.push_back(make_req(sha_pkg::MODE_FINISH, 32'h0, 3'd0));

      // Random part: whole messages, lengths biased to the padding borders.
      while (pending_req_q.size() < TARGET_ITEMS) begin
         case ($urandom_range(0, 5))
            0: target = 55 + $urandom_range(0, 1);
            1: target = 63 + $urandom_range(0, 1);
            2: target = 119 + $urandom_range(0, 2);
            default: target = $urandom_range(0, 70);
         endcase
         queue_message(target);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      running = 1'b1;

      while (pending_req_q.size() != 0 || req_valid) @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
